// ===== rtl/lbs_pkg.sv =====
// Shared types and constants for the linear blend skinning core.
package lbs_pkg;
   localparam int PaletteDepth = 256;
   localparam int Influences = 4;
   localparam int SlotW = 8;
   localparam int RowW = 2;
   localparam int AddrW = SlotW + RowW;
   localparam int CompW = 32;
   localparam int WeightW = 16;
   localparam int ProdW = 2 * CompW;
   localparam int RowSumW = ProdW + 2;
   localparam int WprodW = RowSumW + WeightW + 1;
   localparam int AccW = WprodW + 3;
   localparam int PipeDepth = 6;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SKIN = 1'b1;

   typedef logic signed [CompW-1:0] comp_type;
   typedef comp_type [3:0] vec_type;
   typedef logic signed [AccW-1:0] acc_type;

   typedef struct packed {
      logic [SlotW-1:0] slot;
      logic [RowW-1:0] row;
      vec_type data;
   } pal_write_type;

   typedef struct packed {
      logic operation;
      logic [SlotW-1:0] bone_slot;
      logic [RowW-1:0] row_select;
      comp_type comp_x;
      comp_type comp_y;
      comp_type comp_z;
      comp_type comp_w;
      logic [31:0] influence_bones;
      logic [62:0] influence_weights;
   } req_type;

   typedef struct packed {
      comp_type out_x;
      comp_type out_y;
      comp_type out_z;
      comp_type out_w;
      logic saturated;
   } rsp_type;
endpackage

// ===== rtl/lbs_if.sv =====
// Valid/ready channel interface carrying one item.
interface lbs_req_if;
   import lbs_pkg::*;
   logic valid;
   logic ready;
   req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface lbs_rsp_if;
   import lbs_pkg::*;
   logic valid;
   logic ready;
   rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/lbs_lane.sv =====
// One influence lane: palette copy, 4x4 transform and weighting.
module lbs_lane (
   input logic clock,
   input logic adv,
   input logic wr_en,
   input lbs_pkg::pal_write_type wr,
   input logic [lbs_pkg::SlotW-1:0] bone,
   input logic [lbs_pkg::WeightW-1:0] weight,
   input lbs_pkg::vec_type vec,
   output lbs_pkg::acc_type [3:0] contrib
);
   import lbs_pkg::*;

   vec_type row_q [4];
   logic use_ff, use2_ff, use3_ff;
   vec_type vec_ff;
   logic [WeightW-1:0] w_ff, w2_ff, w3_ff;
   logic signed [ProdW-1:0] prod_ff [4][4];
   logic signed [RowSumW-1:0] sum_in [4];
   logic signed [RowSumW-1:0] rsum_ff [4];
   logic signed [WprodW-1:0] wp_ff [4];

   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [4*CompW-1:0] mem [PaletteDepth];
      vec_type row_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr.row == RowW'(k))) begin
            mem[wr.slot] <= wr.data;
         end
         if (adv) begin
            row_ff <= mem[bone];
         end
      end

      assign row_q[k] = row_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         use_ff <= (weight != '0) && (32'(bone) < PaletteDepth);
         vec_ff <= vec;
         w_ff <= weight;
         for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 4; k++) begin
               prod_ff[j][k] <= use_ff ? ProdW'(vec_ff[3-k] * row_q[k][3-j]) : '0;
            end
         end
         w2_ff <= w_ff;
         use2_ff <= use_ff;
         for (int j = 0; j < 4; j++) begin
            rsum_ff[j] <= sum_in[j];
         end
         w3_ff <= w2_ff;
         use3_ff <= use2_ff;
         for (int j = 0; j < 4; j++) begin
            wp_ff[j] <= use3_ff ? WprodW'(rsum_ff[j] * $signed({1'b0, w3_ff})) : '0;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sum_in[j] = RowSumW'(prod_ff[j][0]) + RowSumW'(prod_ff[j][1])
                   + RowSumW'(prod_ff[j][2]) + RowSumW'(prod_ff[j][3]);
         contrib[j] = AccW'(wp_ff[j]);
      end
   end
endmodule

// ===== rtl/lbs_merge.sv =====
// Merge stage: sum lane contributions, round and saturate.
module lbs_merge (
   input logic clock,
   input logic adv,
   input lbs_pkg::acc_type [lbs_pkg::Influences-1:0][3:0] contrib,
   output lbs_pkg::rsp_type rsp
);
   import lbs_pkg::*;

   acc_type sum_ff [4];
   acc_type sum_in [4];
   acc_type r;
   comp_type res [4];
   logic [3:0] clip;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sum_in[j] = '0;
         for (int i = 0; i < Influences; i++) begin
            sum_in[j] = sum_in[j] + contrib[i][j];
         end
      end
      r = '0;
      for (int j = 0; j < 4; j++) begin
         r = sum_ff[j] + (AccW'(1) <<< 46);
         r = r >>> 47;
         clip[j] = 1'b0;
         if (r > AccW'(32'sh7fffffff)) begin
            res[j] = 32'sh7fffffff;
            clip[j] = 1'b1;
         end else if (r < -(AccW'(1) <<< 31)) begin
            res[j] = 32'sh80000000;
            clip[j] = 1'b1;
         end else begin
            res[j] = r[CompW-1:0];
         end
      end
      rsp.out_x = res[0];
      rsp.out_y = res[1];
      rsp.out_z = res[2];
      rsp.out_w = res[3];
      rsp.saturated = |clip;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sum_in;
      end
   end
endmodule

// ===== rtl/linear_blend_skinning_core.sv =====
// Four-lane linear blend skinning core, top level.
// One item per cycle: palette writes and skin vectors both enter at one per clock.
// A skin result passes the palette read, product, row sum, weighting, merge and output
// registers; writes give none. The pipeline stalls only while the output register is
// full and not taken. Each of the four influence lanes holds its own copy of the
// 256-matrix palette, split into four row banks so a whole matrix is read at once, so all
// influences are read in parallel. Unwritten palette rows read undefined.
module linear_blend_skinning_core (
   input logic clock,
   input logic reset,
   lbs_req_if.sink req,
   lbs_rsp_if.source rsp
);
   import lbs_pkg::*;

   logic [PipeDepth-1:0] vld_ff;
   logic adv;
   pal_write_type wr;
   logic wr_en;
   acc_type [Influences-1:0][3:0] contrib;
   vec_type vec;
   logic [Influences*WeightW-1:0] wts;
   logic [Influences*SlotW-1:0] bones;
   rsp_type res;
   rsp_type out_ff;

   assign adv = !vld_ff[PipeDepth-1] || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = vld_ff[PipeDepth-1];

   assign wr_en = req.valid && req.ready && (req.payload.operation == OP_WRITE)
                && (32'(req.payload.bone_slot) < PaletteDepth);
   assign wr.slot = req.payload.bone_slot;
   assign wr.row = req.payload.row_select;
   assign wr.data = {req.payload.comp_x, req.payload.comp_y,
                     req.payload.comp_z, req.payload.comp_w};
   assign vec = wr.data;
   assign wts = (Influences*WeightW)'({1'b0, req.payload.influence_weights});
   assign bones = (Influences*SlotW)'(req.payload.influence_bones);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PipeDepth-2:0],
                    req.valid && (req.payload.operation == OP_SKIN)};
      end
   end

   for (genvar i = 0; i < Influences; i++) begin : g_lane
      lbs_lane u_lane (
         .clock(clock),
         .adv(adv),
         .wr_en(wr_en),
         .wr(wr),
         .bone(bones[SlotW*i +: SlotW]),
         .weight(wts[WeightW*i +: WeightW]),
         .vec(vec),
         .contrib(contrib[i])
      );
   end

   lbs_merge u_merge (
      .clock(clock),
      .adv(adv),
      .contrib(contrib),
      .rsp(res)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= res;
      end
   end
   assign rsp.payload = out_ff;

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input blocked with empty output");
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.payload.operation == OP_WRITE |=> !vld_ff[0])
      else $error("write item produced a result");
`endif
endmodule
